>>> hw/rtl/ura_pkg.sv
package ura_pkg;

  // Word field widths on the channels
  localparam int VALUE_W = 64;
  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 7;

  // One digit of any base up to sixteen
  localparam int DIGIT_W = 4;

  // Legal base range; anything outside is pulled to the nearest end
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  // Quotient bits resolved per clock in the divider
  localparam int DIV_STEPS = 8;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // ASCII anchors
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = CHAR_W'(65);
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = CHAR_W'(97);
  localparam logic [DIGIT_W-1:0] DIGIT_TEN    = DIGIT_W'(10);

  // Per-item control that travels with the value through the queue
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               upper_case;
  } ura_cmd_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                       input logic upper);
    logic [CHAR_W-1:0] d_ext;
    logic [CHAR_W-1:0] ten_ext;
    d_ext   = CHAR_W'(d);
    ten_ext = CHAR_W'(DIGIT_TEN);
    if (d < DIGIT_TEN) begin
      return ASCII_ZERO + d_ext;
    end else if (upper) begin
      return ASCII_UPPER_A + d_ext - ten_ext;
    end else begin
      return ASCII_LOWER_A + d_ext - ten_ext;
    end
  endfunction

endpackage

>>> hw/rtl/ura_in_if.sv
interface ura_in_if;
  logic                           valid;
  logic                           ready;
  logic [ura_pkg::VALUE_W-1:0]    value;
  logic [ura_pkg::RADIX_W-1:0]    radix;
  logic                           upper_case;

  modport source (output valid, output value, output radix, output upper_case, input ready);
  modport sink   (input valid, input value, input radix, input upper_case, output ready);
endinterface

>>> hw/rtl/ura_out_if.sv
interface ura_out_if;
  logic                           valid;
  logic                           ready;
  logic [ura_pkg::CHAR_W-1:0]     digit_char;
  logic                           last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

>>> hw/rtl/unsigned_radix_to_ascii.sv
// Channel  | Dir | Fields                              | Word
// ---------+-----+-------------------------------------+-------------------------------
// in_chan  | in  | value[63:0] radix[4:0] upper_case   | one number to convert
// out_chan | out | digit_char[6:0] last                | one ASCII digit, MSD first
//
// An item is loaded from the queue, then divided one digit at a time in divider passes
// of 8 quotient bits per cycle, then drained through the stack's registered read, each
// digit passing through a read state and then an output state.
// rst_n is synchronous and clears only the queue pointers and count and the back-end state.
// A stall on out_chan holds the current digit; in_chan keeps accepting until the
// two-entry queue between front and back fills.
module unsigned_radix_to_ascii #(
  parameter int VALUE_WIDTH = ura_pkg::VALUE_W
) (
  input  logic       clk,
  input  logic       rst_n,
  ura_in_if.sink     in_chan,
  ura_out_if.source  out_chan
);

  // Front to queue
  logic                   push;
  logic                   full;
  logic [VALUE_WIDTH-1:0] push_value;
  ura_pkg::ura_cmd_t      push_cmd;

  // Queue to back
  logic                   pop;
  logic                   not_empty;
  logic [VALUE_WIDTH-1:0] pop_value;
  ura_pkg::ura_cmd_t      pop_cmd;

  // Accept, mask the value, clamp the base
  ura_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_chan (in_chan),
    .q_full  (full),
    .q_push  (push),
    .q_value (push_value),
    .q_cmd   (push_cmd)
  );

  // Decouple intake from the long per-item conversion
  ura_queue #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_value (push_value),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .pop_value  (pop_value),
    .pop_cmd    (pop_cmd)
  );

  // Divide out digits into the stack, then drain it most significant first
  ura_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (not_empty),
    .q_value     (pop_value),
    .q_cmd       (pop_cmd),
    .q_pop       (pop),
    .out_chan    (out_chan)
  );

endmodule

>>> hw/rtl/ura_front.sv
module ura_front #(
  parameter int VALUE_WIDTH = ura_pkg::VALUE_W
) (
  ura_in_if.sink                   in_chan,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [VALUE_WIDTH-1:0]   q_value,
  output ura_pkg::ura_cmd_t        q_cmd
);

  // Accept whenever the queue has room
  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  // Drop value bits above the configured width
  assign q_value = in_chan.value[VALUE_WIDTH-1:0];

  // Clamp base into the legal range
  always_comb begin
    priority if (in_chan.radix < ura_pkg::RADIX_MIN) begin
      q_cmd.radix = ura_pkg::RADIX_MIN;
    end else if (in_chan.radix > ura_pkg::RADIX_MAX) begin
      q_cmd.radix = ura_pkg::RADIX_MAX;
    end else begin
      q_cmd.radix = in_chan.radix;
    end
    q_cmd.upper_case = in_chan.upper_case;
  end

endmodule

>>> hw/rtl/ura_queue.sv
module ura_queue #(
  parameter int VALUE_WIDTH = ura_pkg::VALUE_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [VALUE_WIDTH-1:0]   push_value,
  input  ura_pkg::ura_cmd_t        push_cmd,
  output logic                     full,
  input  logic                     pop,
  output logic                     not_empty,
  output logic [VALUE_WIDTH-1:0]   pop_value,
  output ura_pkg::ura_cmd_t        pop_cmd
);

  localparam int DEPTH = ura_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [VALUE_WIDTH-1:0] val_mem [DEPTH];
  ura_pkg::ura_cmd_t      cmd_mem [DEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_value = val_mem[rd_ptr_r];
  assign pop_cmd   = cmd_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      val_mem[wr_ptr_r] <= push_value;
      cmd_mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/ura_back.sv
module ura_back #(
  parameter int VALUE_WIDTH = ura_pkg::VALUE_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_not_empty,
  input  logic [VALUE_WIDTH-1:0]   q_value,
  input  ura_pkg::ura_cmd_t        q_cmd,
  output logic                     q_pop,
  ura_out_if.source                out_chan
);

  localparam int STEPS  = ura_pkg::DIV_STEPS;
  localparam int DIV_W  = ((VALUE_WIDTH + STEPS - 1) / STEPS) * STEPS;
  localparam int NPASS  = DIV_W / STEPS;
  localparam int SW     = (NPASS > 1) ? $clog2(NPASS) : 1;
  localparam int AW     = $clog2(VALUE_WIDTH);
  localparam int DW     = ura_pkg::DIGIT_W;
  localparam int RW     = ura_pkg::RADIX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    radix_r, radix_nxt;
  logic             upper_r, upper_nxt;
  logic [SW-1:0]    pass_r, pass_nxt;
  logic [AW-1:0]    wr_idx_r, wr_idx_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;

  // Divider pass: STEPS restoring steps on a narrow remainder
  logic [DW-1:0]    rem_w;
  logic [DW:0]      trial;
  logic [STEPS-1:0] qbits;
  logic [DIV_W-1:0] quo_div;

  // Digit stack, least significant digit at index zero
  logic [DW-1:0]    dig_mem [VALUE_WIDTH];
  logic             mem_we;
  logic [DW-1:0]    rd_data_r;

  always_comb begin
    rem_w = rem_r;
    qbits = '0;
    trial = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial = {rem_w, quo_r[DIV_W-1-i]};
      if (trial >= {1'b0, radix_r[DW-1:0]} + ((radix_r[DW]) ? (DW+1)'(1 << DW) : '0)) begin
        trial = trial - (DW+1)'(radix_r);
        qbits[STEPS-1-i] = 1'b1;
      end
      rem_w = trial[DW-1:0];
    end
    quo_div = (quo_r << STEPS) | DIV_W'(qbits);
  end

  always_comb begin
    state_nxt  = state_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    radix_nxt  = radix_r;
    upper_nxt  = upper_r;
    pass_nxt   = pass_r;
    wr_idx_nxt = wr_idx_r;
    ptr_nxt    = ptr_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop      = 1'b1;
          quo_nxt    = DIV_W'(q_value);
          rem_nxt    = '0;
          radix_nxt  = q_cmd.radix;
          upper_nxt  = q_cmd.upper_case;
          pass_nxt   = '0;
          wr_idx_nxt = '0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        quo_nxt = quo_div;
        rem_nxt = rem_w;
        if (pass_r == SW'(NPASS - 1)) begin
          // Digit complete: push it, restart the remainder
          mem_we   = 1'b1;
          rem_nxt  = '0;
          pass_nxt = '0;
          if (quo_div == '0) begin
            ptr_nxt   = wr_idx_r;
            state_nxt = S_RD;
          end else begin
            wr_idx_nxt = wr_idx_r + AW'(1);
          end
        end else begin
          pass_nxt = pass_r + SW'(1);
        end
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_chan.ready) begin
          if (ptr_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r - AW'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    radix_r  <= radix_nxt;
    upper_r  <= upper_nxt;
    pass_r   <= pass_nxt;
    wr_idx_r <= wr_idx_nxt;
    ptr_r    <= ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dig_mem[wr_idx_r] <= rem_w;
    end
    rd_data_r <= dig_mem[ptr_r];
  end

  assign out_chan.valid      = (state_r == S_OUT);
  assign out_chan.digit_char = ura_pkg::digit_to_ascii(rd_data_r, upper_r);
  assign out_chan.last       = (ptr_r == '0);

endmodule
